// ----- src/bil_pkg.sv -----
// Shared types, constants and fixed-point helpers for the body integrate and line bounce block.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package bil_pkg;

    // Word format: signed Q16.16 in 32 bits.
    localparam int W       = 32;
    localparam int F       = 16;
    localparam int SB      = W + 16;
    localparam int PW      = 2 * W;
    localparam int TW      = 10;
    localparam int SQ_BITS = (W + F + 1) / 2;
    localparam int SQN     = 2 * SQ_BITS;
    localparam int DIV_LAT = W + 2;

    typedef logic signed [W-1:0] word_t;

    localparam word_t MAXW = {1'b0, {(W-1){1'b1}}};
    localparam word_t MINW = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [SB-1:0] MAXS = {{(SB-W){1'b0}}, MAXW};
    localparam logic signed [SB-1:0] MINS = {{(SB-W){1'b1}}, MINW};
    localparam logic [PW-1:0] PLIM = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [PW-1:0] NLIM = {{(PW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

    // Result error codes.
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_NEG_DISC = 2'd1;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_ACCEL_X = 2'd0;
    localparam logic [1:0] REG_ACCEL_Y = 2'd1;
    localparam logic [1:0] REG_TICK    = 2'd2;

    typedef struct packed {
        logic               func;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] line_h;
        logic signed [31:0] line_k;
        logic signed [31:0] line_l;
    } in_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic [1:0]         error_code;
    } out_t;

    // Sign extension of a word to the sum width.
    function automatic logic signed [SB-1:0] ext(input word_t x);
        return {{(SB-W){x[W-1]}}, x};
    endfunction

    // Saturation of a wide sum to the word range.
    function automatic word_t sat_w(input logic signed [SB-1:0] x);
        if (x > MAXS) begin
            return MAXW;
        end else if (x < MINS) begin
            return MINW;
        end
        return x[W-1:0];
    endfunction

    // Halving with truncation toward zero.
    function automatic logic signed [SB-1:0] half_tz(input logic signed [SB-1:0] x);
        logic signed [SB-1:0] t;
        t = x + $signed({{(SB-1){1'b0}}, x[SB-1]});
        return t >>> 1;
    endfunction

    function automatic word_t half_w(input word_t x);
        logic signed [SB-1:0] t;
        t = half_tz(ext(x));
        return t[W-1:0];
    endfunction

    // Fixed-point product: magnitude shifted right by F, then saturated.
    function automatic word_t mulq(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] sh;
        mag = p[PW-1] ? -p : p;
        sh  = mag >> F;
        if (p[PW-1]) begin
            if (sh > NLIM) begin
                return MINW;
            end
            return ~sh[W-1:0] + 1'b1;
        end
        if (sh > PLIM) begin
            return MAXW;
        end
        return sh[W-1:0];
    endfunction

endpackage

// ----- src/bil_div.sv -----
// Pipelined fixed-point divider: (|num| << F) / |den|, one quotient bit per stage, saturated.
// Depends on bil_pkg. A new operand pair may enter every cycle.
`timescale 1ns / 1ps

module bil_div
    import bil_pkg::*;
(
    input  logic  aclk,
    input  word_t num,
    input  word_t den,
    output word_t quo
);

    logic [W-1:0] amag;
    logic [W-1:0] dmag;
    logic         over0;

    logic [W-1:0] d_reg    [0:W];
    logic [W-1:0] rem_reg  [0:W];
    logic [W-1:0] nlo_reg  [0:W];
    logic [W-1:0] q_reg    [0:W];
    logic         neg_reg  [0:W];
    logic         over_reg [0:W];
    logic         zero_reg [0:W];

    logic [W-1:0] rem_next [1:W];
    logic [W-1:0] q_next   [1:W];
    word_t        quo_reg;

    // Operand magnitudes and the early overflow check.
    always_comb begin
        amag  = num[W-1] ? -num : num;
        dmag  = den[W-1] ? -den : den;
        over0 = ({{W{1'b0}}, amag} << F) >= {dmag, {W{1'b0}}};
    end

    // One restoring step per stage.
    always_comb begin
        logic [W:0] sh;
        logic       ge;
        for (int j = 1; j <= W; j++) begin
            sh          = {rem_reg[j-1], nlo_reg[j-1][W-1]};
            ge          = sh >= {1'b0, d_reg[j-1]};
            rem_next[j] = ge ? W'(sh - {1'b0, d_reg[j-1]}) : sh[W-1:0];
            q_next[j]   = {q_reg[j-1][W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        d_reg[0]    <= dmag;
        rem_reg[0]  <= amag >> (W - F);
        nlo_reg[0]  <= {amag[W-F-1:0], {F{1'b0}}};
        q_reg[0]    <= '0;
        neg_reg[0]  <= num[W-1] ^ den[W-1];
        over_reg[0] <= over0;
        zero_reg[0] <= (dmag == '0);
        for (int j = 1; j <= W; j++) begin
            d_reg[j]    <= d_reg[j-1];
            rem_reg[j]  <= rem_next[j];
            nlo_reg[j]  <= nlo_reg[j-1] << 1;
            q_reg[j]    <= q_next[j];
            neg_reg[j]  <= neg_reg[j-1];
            over_reg[j] <= over_reg[j-1];
            zero_reg[j] <= zero_reg[j-1];
        end
    end

    // Sign and saturation of the finished quotient.
    always_ff @(posedge aclk) begin
        if (zero_reg[W]) begin
            quo_reg <= '0;
        end else if (neg_reg[W]) begin
            if (over_reg[W] || q_reg[W] > {1'b1, {(W-1){1'b0}}}) begin
                quo_reg <= MINW;
            end else begin
                quo_reg <= ~q_reg[W] + 1'b1;
            end
        end else begin
            if (over_reg[W] || q_reg[W] > MAXW) begin
                quo_reg <= MAXW;
            end else begin
                quo_reg <= q_reg[W];
            end
        end
    end

    assign quo = quo_reg;

endmodule

// ----- src/body_integrate_and_line_bounce.sv -----
// Body integrate and line bounce: fixed-point physics step for one body per transfer.
// Depends on bil_pkg and bil_div.
//
// s_data carries func, position, velocity and a line k*x - h*y + l = 0. func 0 advances
// the body by one tick of constant acceleration; func 1 bounces it off the line. Each
// input transfer gives exactly one m_data transfer, in order, with an error code.
// The cfg channel writes accel_x (index 0), accel_y (1) and tick_length (2); cfg_ready is
// always high. Writes must be made while no item is in flight; this is not enforced.
// Throughput is one item per cycle while s_ready is high. The datapath is a fixed
// pipeline of 112 stages (SQ_BITS square root stages plus two DIV_LAT-stage divider pairs
// plus twenty multiply and add stages); with m_ready high a result then passes the
// result buffer and the output register before it shows on m_valid.
// Finished results collect in a buffer of 2**FIFO_AW entries in front of the output
// register. A credit count of items in flight, buffered or in the output register drops
// s_ready when it reaches the buffer depth, so a stalled receiver never loses a result.
// Reset clears the pipeline valid bits, the buffer and the credit count, and sets
// accel_x and accel_y to 0 and tick_length to 16.
`timescale 1ns / 1ps

module body_integrate_and_line_bounce
    import bil_pkg::*;
#(
    parameter int FIFO_AW = 7
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int DEPTH   = 1 << FIFO_AW;
    localparam int S_DISC  = 6;
    localparam int S_ROOT  = S_DISC + SQ_BITS;
    localparam int S_NUM   = S_ROOT + 1;
    localparam int S_DQ    = S_NUM + DIV_LAT;
    localparam int S_DT    = S_DQ + 1;
    localparam int S_RAW1  = S_DT + 1;
    localparam int S_AD    = S_RAW1 + 1;
    localparam int S_V0    = S_AD + 1;
    localparam int S_HX    = S_V0 + 1;
    localparam int S_P0    = S_HX + 1;
    localparam int S_DOT   = S_P0 + 1;
    localparam int S_NRAW  = S_DOT + 1;
    localparam int S_NK    = S_NRAW + 1;
    localparam int S_RQ    = S_NK + DIV_LAT;
    localparam int S_V1    = S_RQ + 1;
    localparam int S_FRAW  = S_V1 + 1;
    localparam int S_FM    = S_FRAW + 1;
    localparam int LAST    = S_FM + 1;

    // Per-item state carried down the pipeline.
    typedef struct packed {
        logic  func;
        word_t px, py, vx, vy, h, k, l;
        word_t e, f, g, m2;
        word_t atx, aty, vxt, vyt;
        word_t disc, numa, dena, numb;
        word_t dt, adx, ady, mvx, mvy;
        word_t v0x, v0y, hx, hy, p0x, p0y;
        word_t dot, nk, nh, v1x, v1y;
        out_t  res;
    } st_t;

    // Configuration registers.
    word_t         accel_x_reg;
    word_t         accel_y_reg;
    logic [TW-1:0] tick_reg;
    logic signed [TW:0] tick_s;

    st_t  line_reg   [1:LAST];
    st_t  line_next  [1:LAST];
    logic valid_reg  [1:LAST];

    logic signed [PW-1:0] r1_axk, r1_ayh, r1_vyh, r1_vxk, r1_pxk, r1_pyh, r1_kk, r1_hh;
    logic signed [SB-1:0] r1_atx, r1_aty, r1_vxt, r1_vyt;
    word_t                r2_maxk, r2_mayh, r2_mvyh, r2_mvxk, r2_mpxk, r2_mpyh;
    word_t                r2_mkk, r2_mhh, r2_atx, r2_aty, r2_vxt, r2_vyt;
    logic signed [SB-1:0] r3_atxt, r3_atyt;
    logic signed [PW-1:0] r4_ff, r4_eg;
    word_t                r4_hfx, r4_hfy;
    word_t                r5_mff, r5_meg;

    logic [SQN-1:0]     sq_rem_reg   [1:SQ_BITS];
    logic [SQ_BITS-1:0] sq_root_reg  [1:SQ_BITS];
    logic [SQN-1:0]     sq_rem_next  [1:SQ_BITS];
    logic [SQ_BITS-1:0] sq_root_next [1:SQ_BITS];

    word_t                qa, qb, qc, qd;
    logic signed [PW-1:0] r_axdt, r_aydt, r_vxdt, r_vydt;
    logic signed [PW-1:0] r_adxdt, r_adydt, r_v0xk, r_v0yh;
    word_t                r_mv0xk, r_mv0yh;
    logic signed [PW-1:0] r_dk, r_dnh, r_fx, r_fy;
    word_t                r_mfx, r_mfy;

    // Result buffer and credits.
    out_t               mem [0:DEPTH-1];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   mem_cnt_reg, mem_cnt_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic               m_valid_reg;
    out_t               m_data_reg;
    logic               in_fire, out_fire, wr_en, rd_en;

    assign cfg_ready = 1'b1;
    assign tick_s    = $signed({1'b0, tick_reg});
    assign s_ready   = cnt_reg < (FIFO_AW+1)'(DEPTH);
    assign in_fire   = s_valid && s_ready;
    assign out_fire  = m_valid_reg && m_ready;
    assign wr_en     = valid_reg[LAST];
    assign rd_en     = (mem_cnt_reg != '0) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_x_reg <= '0;
            accel_y_reg <= '0;
            tick_reg    <= TW'(16);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ACCEL_X: accel_x_reg <= cfg_data;
                REG_ACCEL_Y: accel_y_reg <= cfg_data;
                REG_TICK:    tick_reg    <= cfg_data[TW-1:0];
                default:     ;
            endcase
        end
    end

    // Single-stage products and roundings that feed the carried state.
    always_ff @(posedge aclk) begin
        r1_axk  <= accel_x_reg * s_data.line_k;
        r1_ayh  <= accel_y_reg * s_data.line_h;
        r1_vyh  <= s_data.vel_y * s_data.line_h;
        r1_vxk  <= s_data.vel_x * s_data.line_k;
        r1_pxk  <= s_data.pos_x * s_data.line_k;
        r1_pyh  <= s_data.pos_y * s_data.line_h;
        r1_kk   <= s_data.line_k * s_data.line_k;
        r1_hh   <= s_data.line_h * s_data.line_h;
        r1_atx  <= accel_x_reg * tick_s;
        r1_aty  <= accel_y_reg * tick_s;
        r1_vxt  <= s_data.vel_x * tick_s;
        r1_vyt  <= s_data.vel_y * tick_s;

        r2_maxk <= mulq(r1_axk);
        r2_mayh <= mulq(r1_ayh);
        r2_mvyh <= mulq(r1_vyh);
        r2_mvxk <= mulq(r1_vxk);
        r2_mpxk <= mulq(r1_pxk);
        r2_mpyh <= mulq(r1_pyh);
        r2_mkk  <= mulq(r1_kk);
        r2_mhh  <= mulq(r1_hh);
        r2_atx  <= sat_w(r1_atx);
        r2_aty  <= sat_w(r1_aty);
        r2_vxt  <= sat_w(r1_vxt);
        r2_vyt  <= sat_w(r1_vyt);

        r3_atxt <= r2_atx * tick_s;
        r3_atyt <= r2_aty * tick_s;

        r4_ff   <= line_reg[3].f * line_reg[3].f;
        r4_eg   <= line_reg[3].e * line_reg[3].g;
        r4_hfx  <= half_w(sat_w(r3_atxt));
        r4_hfy  <= half_w(sat_w(r3_atyt));

        r5_mff  <= mulq(r4_ff);
        r5_meg  <= mulq(r4_eg);

        r_axdt  <= accel_x_reg * line_reg[S_DT].dt;
        r_aydt  <= accel_y_reg * line_reg[S_DT].dt;
        r_vxdt  <= line_reg[S_DT].vx * line_reg[S_DT].dt;
        r_vydt  <= line_reg[S_DT].vy * line_reg[S_DT].dt;

        r_adxdt <= line_reg[S_AD].adx * line_reg[S_AD].dt;
        r_adydt <= line_reg[S_AD].ady * line_reg[S_AD].dt;

        r_v0xk  <= line_reg[S_V0].v0x * line_reg[S_V0].k;
        r_v0yh  <= line_reg[S_V0].v0y * line_reg[S_V0].h;

        r_mv0xk <= mulq(r_v0xk);
        r_mv0yh <= mulq(r_v0yh);

        r_dk    <= line_reg[S_DOT].dot * line_reg[S_DOT].k;
        r_dnh   <= line_reg[S_DOT].dot * sat_w(-ext(line_reg[S_DOT].h));

        r_fx    <= line_reg[S_V1].v1x * line_reg[S_V1].dt;
        r_fy    <= line_reg[S_V1].v1y * line_reg[S_V1].dt;

        r_mfx   <= mulq(r_fx);
        r_mfy   <= mulq(r_fy);
    end

    // Square root of disc << F, one result bit per stage.
    always_comb begin
        logic [SQN-1:0]     rin;
        logic [SQN-1:0]     trial;
        logic [SQ_BITS-1:0] rtin;
        for (int j = 1; j <= SQ_BITS; j++) begin
            if (j == 1) begin
                if (line_reg[S_DISC].disc[W-1]) begin
                    rin = '0;
                end else begin
                    rin = SQN'({line_reg[S_DISC].disc, {F{1'b0}}});
                end
                rtin = '0;
            end else begin
                rin  = sq_rem_reg[j-1];
                rtin = sq_root_reg[j-1];
            end
            trial = (SQN'(rtin) << (SQ_BITS - j + 1)) + (SQN'(1) << (2 * (SQ_BITS - j)));
            if (rin >= trial) begin
                sq_rem_next[j]  = rin - trial;
                sq_root_next[j] = rtin | (SQ_BITS'(1) << (SQ_BITS - j));
            end else begin
                sq_rem_next[j]  = rin;
                sq_root_next[j] = rtin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 1; j <= SQ_BITS; j++) begin
            sq_rem_reg[j]  <= sq_rem_next[j];
            sq_root_reg[j] <= sq_root_next[j];
        end
    end

    // Dividers for the crossing time and for the reflection terms.
    bil_div u_div_a (.aclk(aclk), .num(line_reg[S_NUM].numa), .den(line_reg[S_NUM].dena),
                     .quo(qa));
    bil_div u_div_b (.aclk(aclk), .num(line_reg[S_NUM].numb), .den(line_reg[S_NUM].e),
                     .quo(qb));
    bil_div u_div_c (.aclk(aclk), .num(line_reg[S_NK].nk), .den(line_reg[S_NK].m2),
                     .quo(qc));
    bil_div u_div_d (.aclk(aclk), .num(line_reg[S_NK].nh), .den(line_reg[S_NK].m2),
                     .quo(qd));

    // Stage updates of the carried state.
    always_comb begin
        word_t                s_w;
        word_t                na;
        logic signed [SB-1:0] tq;
        logic                 pass;
        logic [1:0]           perr;

        line_next[1]      = '0;
        line_next[1].func = s_data.func;
        line_next[1].px   = s_data.pos_x;
        line_next[1].py   = s_data.pos_y;
        line_next[1].vx   = s_data.vel_x;
        line_next[1].vy   = s_data.vel_y;
        line_next[1].h    = s_data.line_h;
        line_next[1].k    = s_data.line_k;
        line_next[1].l    = s_data.line_l;
        for (int i = 2; i <= LAST; i++) begin
            line_next[i] = line_reg[i-1];
        end

        // Quadratic coefficients and the integration terms.
        line_next[3].e   = sat_w(half_tz(ext(r2_maxk) - ext(r2_mayh)));
        line_next[3].f   = sat_w(ext(r2_mvyh) - ext(r2_mvxk));
        line_next[3].g   = sat_w(ext(r2_mpxk) - ext(r2_mpyh) + ext(line_reg[2].l));
        line_next[3].m2  = sat_w(ext(r2_mkk) + ext(r2_mhh));
        line_next[3].atx = r2_atx;
        line_next[3].aty = r2_aty;
        line_next[3].vxt = r2_vxt;
        line_next[3].vyt = r2_vyt;

        // Integration result.
        line_next[5].res.new_pos_x = sat_w(ext(line_reg[4].px) + ext(line_reg[4].vxt)
                                           + ext(r4_hfx));
        line_next[5].res.new_pos_y = sat_w(ext(line_reg[4].py) + ext(line_reg[4].vyt)
                                           + ext(r4_hfy));
        line_next[5].res.new_vel_x = sat_w(ext(line_reg[4].vx) + ext(line_reg[4].atx));
        line_next[5].res.new_vel_y = sat_w(ext(line_reg[4].vy) + ext(line_reg[4].aty));
        line_next[5].res.error_code = ERR_OK;

        // Discriminant.
        line_next[S_DISC].disc = sat_w(ext(r5_mff) - (ext(r5_meg) <<< 2));

        // Root numerators; a flat quadratic divides -g by f instead.
        s_w = {{(W-SQ_BITS){1'b0}}, sq_root_reg[SQ_BITS]};
        na  = half_w(sat_w(-ext(line_reg[S_ROOT].f) - ext(s_w)));
        line_next[S_NUM].numb = half_w(sat_w(-ext(line_reg[S_ROOT].f) + ext(s_w)));
        if (line_reg[S_ROOT].e == '0) begin
            line_next[S_NUM].numa = sat_w(-ext(line_reg[S_ROOT].g));
            line_next[S_NUM].dena = line_reg[S_ROOT].f;
        end else begin
            line_next[S_NUM].numa = na;
            line_next[S_NUM].dena = line_reg[S_ROOT].e;
        end

        // Root choice: if e is nonzero, the second root when the first lies outside [0, T].
        tq = $signed({{(SB-TW-F){1'b0}}, tick_reg, {F{1'b0}}});
        if (line_reg[S_DQ].e != '0 && (qa < 0 || ext(qa) > tq)) begin
            line_next[S_DT].dt = qb;
        end else begin
            line_next[S_DT].dt = qa;
        end

        // Rewind to the crossing.
        line_next[S_AD].adx = mulq(r_axdt);
        line_next[S_AD].ady = mulq(r_aydt);
        line_next[S_AD].mvx = mulq(r_vxdt);
        line_next[S_AD].mvy = mulq(r_vydt);

        line_next[S_V0].v0x = sat_w(ext(line_reg[S_AD].vx) - ext(line_reg[S_AD].adx));
        line_next[S_V0].v0y = sat_w(ext(line_reg[S_AD].vy) - ext(line_reg[S_AD].ady));

        line_next[S_HX].hx = half_w(mulq(r_adxdt));
        line_next[S_HX].hy = half_w(mulq(r_adydt));

        line_next[S_P0].p0x = sat_w(ext(line_reg[S_HX].hx) - ext(line_reg[S_HX].mvx)
                                    + ext(line_reg[S_HX].px));
        line_next[S_P0].p0y = sat_w(ext(line_reg[S_HX].hy) - ext(line_reg[S_HX].mvy)
                                    + ext(line_reg[S_HX].py));

        // Reflection across the normal (k, -h).
        line_next[S_DOT].dot = sat_w(ext(r_mv0xk) - ext(r_mv0yh));
        line_next[S_NK].nk   = mulq(r_dk);
        line_next[S_NK].nh   = mulq(r_dnh);

        line_next[S_V1].v1x = sat_w(ext(line_reg[S_RQ].v0x) - (ext(qc) <<< 1));
        line_next[S_V1].v1y = sat_w(ext(line_reg[S_RQ].v0y) - (ext(qd) <<< 1));

        // Replay forward and pick the result for the item.
        pass = 1'b0;
        perr = ERR_OK;
        if (line_reg[S_FM].e == '0 && line_reg[S_FM].f == '0) begin
            pass = 1'b1;
            perr = ERR_DIV_ZERO;
        end else if (line_reg[S_FM].e != '0 && line_reg[S_FM].disc[W-1]) begin
            pass = 1'b1;
            perr = ERR_NEG_DISC;
        end else if (line_reg[S_FM].m2 == '0) begin
            pass = 1'b1;
            perr = ERR_DIV_ZERO;
        end
        if (line_reg[S_FM].func) begin
            if (pass) begin
                line_next[LAST].res.new_pos_x = line_reg[S_FM].px;
                line_next[LAST].res.new_pos_y = line_reg[S_FM].py;
                line_next[LAST].res.new_vel_x = line_reg[S_FM].vx;
                line_next[LAST].res.new_vel_y = line_reg[S_FM].vy;
            end else begin
                line_next[LAST].res.new_pos_x = sat_w(ext(line_reg[S_FM].hx) + ext(r_mfx)
                                                      + ext(line_reg[S_FM].p0x));
                line_next[LAST].res.new_pos_y = sat_w(ext(line_reg[S_FM].hy) + ext(r_mfy)
                                                      + ext(line_reg[S_FM].p0y));
                line_next[LAST].res.new_vel_x = sat_w(ext(line_reg[S_FM].v1x)
                                                      + ext(line_reg[S_FM].adx));
                line_next[LAST].res.new_vel_y = sat_w(ext(line_reg[S_FM].v1y)
                                                      + ext(line_reg[S_FM].ady));
            end
            line_next[LAST].res.error_code = perr;
        end
    end

    // Pipeline payload and valid bits.
    always_ff @(posedge aclk) begin
        for (int i = 1; i <= LAST; i++) begin
            line_reg[i] <= line_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= LAST; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            valid_reg[1] <= in_fire;
            for (int i = 2; i <= LAST; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // Credit count of items in flight, buffered or in the output register.
    always_comb begin
        cnt_next = cnt_reg;
        if (in_fire && !out_fire) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!in_fire && out_fire) begin
            cnt_next = cnt_reg - 1'b1;
        end
        mem_cnt_next = mem_cnt_reg;
        if (wr_en && !rd_en) begin
            mem_cnt_next = mem_cnt_reg + 1'b1;
        end else if (!wr_en && rd_en) begin
            mem_cnt_next = mem_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            mem_cnt_reg <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            mem_cnt_reg <= mem_cnt_next;
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg  <= rd_ptr_reg + 1'b1;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result buffer storage and the output register.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= line_reg[LAST].res;
        end
        if (rd_en) begin
            m_data_reg <= mem[rd_ptr_reg];
        end
    end

endmodule
